// File: rtl/core/mdc_pkg.sv
// mdc_pkg: shared types, constants and helpers of the determinant block.
// No dependencies; used by matrix_determinant_cofactor, mdc_mac and mdc_seq.
`default_nettype none

package mdc_pkg;

  // Order register
  localparam int ORD_W  = 3;
  localparam int BASE_W = 2 * ORD_W;
  localparam logic [ORD_W-1:0] ORDER_RESET = 3'd4;

  // Defaults of the top level parameters
  localparam int DEF_MAX_ORDER  = 4;
  localparam int DEF_ENTRY_BITS = 16;

  // Multiplier slice: one limb of the stored minor per cycle
  localparam int LIMB_W     = 32;
  localparam int LIMB_IDX_W = 3;

  // Saturation bounds of the 64-bit result
  localparam int DET_W = 64;
  localparam logic [DET_W-1:0] DET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DET_W-1:0] DET_MIN = 64'h8000_0000_0000_0000;

  // Ceiling of log2 of n!
  function automatic int fact_bits(input int n);
    int f;
    int i;
    f = 1;
    for (i = 2; i <= n; i++) begin
      f = f * i;
    end
    return $clog2(f);
  endfunction

  // Exact width of any minor, never narrower than 65 so the saturation
  // check always has a guard bit above the 64-bit result.
  function automatic int acc_width(input int max_order, input int entry_bits);
    int w;
    w = max_order * entry_bits + fact_bits(max_order) + 1;
    if (w < DET_W + 1) begin
      w = DET_W + 1;
    end
    return w;
  endfunction

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_MUL,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Sequencer to multiply-accumulate unit
  typedef struct packed {
    logic                  clear;
    logic                  mul;
    logic                  sub;
    logic [LIMB_IDX_W-1:0] limb;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/matrix_determinant_cofactor.sv
// Top level of the cofactor-expansion determinant block.
// Depends on mdc_pkg, mdc_ram, mdc_mac and mdc_seq.
//
// Usage:
//   Input channel (in_valid/in_ready/entry): one word per matrix element,
//   row-major, n*n words per matrix, where n is the order register clamped
//   to 1..MAX_ORDER. in_ready is high while loading, one word per cycle.
//   Output channel (out_valid/out_ready/determinant/saturated): one word per
//   matrix, the exact determinant saturated to 64-bit signed, saturated set
//   when the exact value did not fit.
//   Config (cfg_we/cfg_data): writes the order; the user must write only while
//   idle, the block does not enforce it. A write also restarts the current load.
// Compute:
//   After the last element, minors are built bottom-up over column masks
//   in a minor memory (one entry per mask), one entry times one stored minor
//   per term, the minor taken one 32-bit limb per cycle through a single
//   multiplier (NLIMB = 3 limbs for a 4x4 of 16-bit elements). Once the result
//   is taken into the output register, the load of the next matrix may start.
// Reset: order returns to 4, the load count to zero, no output is pending.
// Stall: the result sits in the output register; the next matrix loads
//   meanwhile, and its result waits until the register is taken.
`default_nettype none

module matrix_determinant_cofactor #(
  parameter int MAX_ORDER  = mdc_pkg::DEF_MAX_ORDER,
  parameter int ENTRY_BITS = mdc_pkg::DEF_ENTRY_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [mdc_pkg::ORD_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [ENTRY_BITS-1:0]   entry,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [mdc_pkg::DET_W-1:0]    determinant,
  output logic                                saturated
);

  localparam int ACC_W    = mdc_pkg::acc_width(MAX_ORDER, ENTRY_BITS);
  localparam int NLIMB    = (ACC_W + mdc_pkg::LIMB_W - 1) / mdc_pkg::LIMB_W;
  localparam int MAT_D    = MAX_ORDER * MAX_ORDER;
  localparam int MAT_AW   = $clog2(MAT_D);
  localparam int MIN_D    = 1 << MAX_ORDER;
  localparam int DET_W    = mdc_pkg::DET_W;

  logic [mdc_pkg::ORD_W-1:0] order;

  logic                  mat_we, mat_re;
  logic [MAT_AW-1:0]     mat_waddr, mat_raddr;
  logic [ENTRY_BITS-1:0] mat_rdata;

  logic                  min_we, min_re, min_wone;
  logic [MAX_ORDER-1:0]  min_waddr, min_raddr;
  logic [ACC_W-1:0]      min_wdata, min_rdata;

  mdc_pkg::mac_ctl_t     mac_ctl;
  logic [ACC_W-1:0]      acc;

  logic                  res_load, res_busy;
  logic [ACC_W-DET_W:0]  acc_hi;
  logic                  fits;

  // Order register
  always_ff @(posedge clk) begin
    if (rst) begin
      order <= mdc_pkg::ORDER_RESET;
    end else if (cfg_we) begin
      order <= cfg_data;
    end
  end

  mdc_seq #(
    .MAX_ORDER (MAX_ORDER),
    .NLIMB     (NLIMB)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .order     (order),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mat_we    (mat_we),
    .mat_waddr (mat_waddr),
    .mat_re    (mat_re),
    .mat_raddr (mat_raddr),
    .min_we    (min_we),
    .min_waddr (min_waddr),
    .min_wone  (min_wone),
    .min_re    (min_re),
    .min_raddr (min_raddr),
    .mac_ctl   (mac_ctl),
    .res_busy  (res_busy),
    .res_load  (res_load)
  );

  // Matrix elements, row-major
  mdc_ram #(
    .DEPTH (MAT_D),
    .WIDTH (ENTRY_BITS),
    .AW    (MAT_AW)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (entry),
    .re    (mat_re),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  // Minors indexed by column mask; mask zero holds the constant one
  assign min_wdata = min_wone ? ACC_W'(1) : acc;

  mdc_ram #(
    .DEPTH (MIN_D),
    .WIDTH (ACC_W),
    .AW    (MAX_ORDER)
  ) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (min_waddr),
    .wdata (min_wdata),
    .re    (min_re),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  mdc_mac #(
    .ENTRY_BITS (ENTRY_BITS),
    .ACC_W      (ACC_W),
    .NLIMB      (NLIMB)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .entry_q (mat_rdata),
    .minor_q (min_rdata),
    .acc     (acc)
  );

  // Fits in 64 bits when every bit from 63 up equals the sign
  assign acc_hi = acc[ACC_W-1:DET_W-1];
  assign fits   = (&acc_hi) | ~(|acc_hi);

  assign res_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_load | res_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      saturated <= ~fits;
      if (fits) begin
        determinant <= acc[DET_W-1:0];
      end else if (acc[ACC_W-1]) begin
        determinant <= mdc_pkg::DET_MIN;
      end else begin
        determinant <= mdc_pkg::DET_MAX;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mdc_ram.sv
// mdc_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No package dependencies.
`default_nettype none

module mdc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mdc_mac.sv
// mdc_mac: limb-serial multiply-accumulate of one entry times one minor.
// Depends on mdc_pkg (mac_ctl_t, LIMB_W, LIMB_IDX_W).
`default_nettype none

module mdc_mac #(
  parameter int ENTRY_BITS = 16,
  parameter int ACC_W      = 70,
  parameter int NLIMB      = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mdc_pkg::mac_ctl_t       ctl,
  input  wire logic [ENTRY_BITS-1:0]   entry_q,
  input  wire logic [ACC_W-1:0]        minor_q,
  output logic      [ACC_W-1:0]        acc
);

  localparam int PAD_W  = NLIMB * mdc_pkg::LIMB_W;
  localparam int PROD_W = ENTRY_BITS + mdc_pkg::LIMB_W + 1;

  logic signed [ACC_W-1:0]            minor_s;
  logic        [PAD_W-1:0]            minor_pad;
  logic signed [mdc_pkg::LIMB_W:0]    limb_val;
  logic signed [ENTRY_BITS-1:0]       entry_s;

  logic signed [PROD_W-1:0]           prod;
  logic                               prod_valid;
  logic                               prod_sub;
  logic [mdc_pkg::LIMB_IDX_W-1:0]     prod_limb;

  logic signed [ACC_W-1:0]            term;
  logic        [ACC_W-1:0]            term_sh;

  assign minor_s   = minor_q;
  assign minor_pad = PAD_W'(minor_s);
  assign entry_s   = entry_q;

  // Lower limbs are unsigned, the top limb carries the sign
  always_comb begin
    limb_val = '0;
    for (int k = 0; k < NLIMB; k++) begin
      if (ctl.limb == mdc_pkg::LIMB_IDX_W'(k)) begin
        if (k == NLIMB - 1) begin
          limb_val = {minor_pad[k*mdc_pkg::LIMB_W + mdc_pkg::LIMB_W - 1],
                      minor_pad[k*mdc_pkg::LIMB_W +: mdc_pkg::LIMB_W]};
        end else begin
          limb_val = {1'b0, minor_pad[k*mdc_pkg::LIMB_W +: mdc_pkg::LIMB_W]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod      <= entry_s * limb_val;
      prod_sub  <= ctl.sub;
      prod_limb <= ctl.limb;
    end
  end

  assign term    = ACC_W'(prod);
  assign term_sh = term << (prod_limb * mdc_pkg::LIMB_W);

  // Modulo 2^ACC_W arithmetic; every finished minor fits exactly
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= prod_sub ? (acc - term_sh) : (acc + term_sh);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mdc_seq.sv
// mdc_seq: load counter and minor-walk sequencer of the determinant block.
// Depends on mdc_pkg (state_t, mac_ctl_t, ORD_W, BASE_W, LIMB_IDX_W).
`default_nettype none

module mdc_seq #(
  parameter int MAX_ORDER = 4,
  parameter int NLIMB     = 3
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic [mdc_pkg::ORD_W-1:0]               order,
  input  wire logic                                    cfg_we,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  output logic                                         mat_we,
  output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0]       mat_waddr,
  output logic                                         mat_re,
  output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0]       mat_raddr,
  output logic                                         min_we,
  output logic [MAX_ORDER-1:0]                         min_waddr,
  output logic                                         min_wone,
  output logic                                         min_re,
  output logic [MAX_ORDER-1:0]                         min_raddr,
  output mdc_pkg::mac_ctl_t                            mac_ctl,
  input  wire logic                                    res_busy,
  output logic                                         res_load
);

  localparam int ADDR_W = $clog2(MAX_ORDER * MAX_ORDER);
  localparam int MASK_W = MAX_ORDER;
  localparam int C_W    = $clog2(MAX_ORDER);
  localparam int ORD_W  = mdc_pkg::ORD_W;
  localparam int BASE_W = mdc_pkg::BASE_W;
  localparam logic [mdc_pkg::LIMB_IDX_W-1:0] LIMB_LAST =
    mdc_pkg::LIMB_IDX_W'(NLIMB - 1);

  mdc_pkg::state_t state, state_next;

  logic [ADDR_W-1:0]              count, count_next;
  logic [MASK_W-1:0]              mask, mask_next;
  logic [MASK_W-1:0]              rem, rem_next;
  logic                           neg, neg_next;
  logic [mdc_pkg::LIMB_IDX_W-1:0] limb, limb_next;

  logic [ORD_W-1:0]  n;
  logic [BASE_W-1:0] total;
  logic [ADDR_W:0]   count_inc;
  logic [MASK_W-1:0] full_mask;
  logic [MASK_W-1:0] low_bit;
  logic [C_W-1:0]    col;
  logic [ORD_W-1:0]  pop;
  logic [ORD_W-1:0]  row;
  logic [BASE_W-1:0] row_addr;

  // Effective order: zero reads as one, large values clamp
  always_comb begin
    if (order == '0) begin
      n = ORD_W'(1);
    end else if (order > ORD_W'(MAX_ORDER)) begin
      n = ORD_W'(MAX_ORDER);
    end else begin
      n = order;
    end
  end

  assign total     = BASE_W'(n) * BASE_W'(n);
  assign count_inc = {1'b0, count} + 1'b1;
  assign full_mask = ~({MASK_W{1'b1}} << n);

  // Next column of the current minor: lowest remaining bit
  assign low_bit = rem & (~rem + 1'b1);

  always_comb begin
    col = '0;
    for (int i = MAX_ORDER - 1; i >= 0; i--) begin
      if (rem[i]) begin
        col = C_W'(i);
      end
    end
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      pop = pop + ORD_W'(mask[i]);
    end
  end

  // A minor over k columns uses the bottom k rows
  assign row       = n - pop;
  assign row_addr  = BASE_W'(row) * BASE_W'(n) + BASE_W'(col);
  assign mat_raddr = row_addr[ADDR_W-1:0];
  assign min_raddr = mask & ~low_bit;
  assign mat_waddr = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdc_pkg::ST_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    mask <= mask_next;
    rem  <= rem_next;
    neg  <= neg_next;
    limb <= limb_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    mask_next  = mask;
    rem_next   = rem;
    neg_next   = neg;
    limb_next  = limb;

    in_ready   = 1'b0;
    mat_we     = 1'b0;
    mat_re     = 1'b0;
    min_we     = 1'b0;
    min_waddr  = mask;
    min_wone   = 1'b0;
    min_re     = 1'b0;
    res_load   = 1'b0;
    mac_ctl    = '0;
    mac_ctl.limb = limb;
    mac_ctl.sub  = neg;

    unique case (state)
      mdc_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mat_we = 1'b1;
          if (count_inc == (ADDR_W + 1)'(total)) begin
            count_next = '0;
            state_next = mdc_pkg::ST_INIT;
          end else begin
            count_next = count_inc[ADDR_W-1:0];
          end
        end
      end

      // Minor of no columns is one
      mdc_pkg::ST_INIT: begin
        min_we        = 1'b1;
        min_waddr     = '0;
        min_wone      = 1'b1;
        mac_ctl.clear = 1'b1;
        mask_next     = MASK_W'(1);
        rem_next      = MASK_W'(1);
        neg_next      = 1'b0;
        state_next    = mdc_pkg::ST_SCAN;
      end

      mdc_pkg::ST_SCAN: begin
        if (rem == '0) begin
          state_next = mdc_pkg::ST_WRITE;
        end else begin
          mat_re     = 1'b1;
          min_re     = 1'b1;
          rem_next   = rem & ~low_bit;
          limb_next  = '0;
          state_next = mdc_pkg::ST_MUL;
        end
      end

      mdc_pkg::ST_MUL: begin
        mac_ctl.mul = 1'b1;
        if (limb == LIMB_LAST) begin
          neg_next   = ~neg;
          state_next = mdc_pkg::ST_SCAN;
        end else begin
          limb_next = limb + 1'b1;
        end
      end

      // The write lands at the end of this state, before the next minor's first read
      mdc_pkg::ST_WRITE: begin
        min_we = 1'b1;
        if (mask == full_mask) begin
          state_next = mdc_pkg::ST_OUT;
        end else begin
          mac_ctl.clear = 1'b1;
          mask_next     = mask + 1'b1;
          rem_next      = mask + 1'b1;
          neg_next      = 1'b0;
          state_next    = mdc_pkg::ST_SCAN;
        end
      end

      mdc_pkg::ST_OUT: begin
        if (!res_busy) begin
          res_load   = 1'b1;
          state_next = mdc_pkg::ST_LOAD;
        end
      end

      default: begin
        state_next = mdc_pkg::ST_LOAD;
      end
    endcase

    if (cfg_we) begin
      count_next = '0;
    end
  end

endmodule

`default_nettype wire
